FILE: rtl/jls_pkg.sv
// Shared types and codes for the Jacobi linear solver.
`default_nettype none
package jls_pkg;

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DOM   = 11'b000_0000_0010,
    S_COPY  = 11'b000_0000_0100,
    S_ROW   = 11'b000_0000_1000,
    S_DIV   = 11'b000_0001_0000,
    S_SAT   = 11'b000_0010_0000,
    S_MUL   = 11'b000_0100_0000,
    S_CMP   = 11'b000_1000_0000,
    S_ORD   = 11'b001_0000_0000,
    S_OLD   = 11'b010_0000_0000,
    S_OWAIT = 11'b100_0000_0000
  } state_t;

  localparam logic [1:0] OP_GUESS = 2'd0;
  localparam logic [1:0] OP_COEF  = 2'd1;
  localparam logic [1:0] OP_CONST = 2'd2;
  localparam logic [1:0] OP_SOLVE = 2'd3;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_NOT_DOM   = 2'd1;
  localparam logic [1:0] ST_ITER_LIM  = 2'd2;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd3;

  localparam logic [1:0] CFG_UNKNOWNS = 2'd0;
  localparam logic [1:0] CFG_TOL      = 2'd1;
  localparam logic [1:0] CFG_MAXIT    = 2'd2;

  localparam int QUOT_BITS = 63;

endpackage
`default_nettype wire

FILE: rtl/jacobi_linear_solver_top.sv
// Jacobi solver: matrix, vector stores and the sweep sequencer.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_tvalid/in_tready   | tuser op, tdata row,column,value
//  out     | out | out_tvalid/out_tready | tdata index,solution,iterations,status; tlast
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Load transactions are accepted only while idle. A solve runs a dominance pass, then per
// sweep a copy pass and per row a read pass, 63 divider steps (one quotient bit per cycle)
// and saturate, multiply and compare steps; each result is then read out and held until
// taken. Input is held off from a solve until its last result is taken. Reset is
// synchronous; stores are not cleared, sequencer registers return to their reset values.
`default_nettype none
module jacobi_linear_solver_top #(
  parameter int MAX_UNKNOWNS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // row[5:0], column[11:6], value[43:12], zero fill
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // index[5:0], solution[37:6], iterations[53:38],
                                       // status[55:54]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IW = (MAX_UNKNOWNS > 2) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int CW = $clog2(MAX_UNKNOWNS * MAX_UNKNOWNS);
  localparam int SW = 32 + IW;
  localparam logic signed [63:0] LIMIT = 64'sd1 <<< (62 - FRAC_BITS);
  localparam logic signed [63:0] RND   = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  // control
  jls_pkg::state_t state_r;
  logic [IW-1:0] ci_r, cj_r, nm1_r;
  logic          iss_done_r;
  logic          p1_v_r, p1_diag_r, p1_eol_r, p1_end_r, p1_first_r;
  logic [IW-1:0] p1_idx_r;
  logic          p2_v_r, p2_diag_r, p2_eol_r;
  logic          fail_r, bigger_r, zero_r, allok_r;
  logic [15:0]   iter_r;
  logic [5:0]    divcnt_r;
  logic          out_valid_r;
  logic [6:0]    unk_r;
  logic [31:0]   tol_r;
  logic [15:0]   maxit_r;

  // datapath
  logic signed [31:0] coef_q, b_q, cur_q, prev_q;
  logic signed [63:0] prod_r, acc_r;
  logic [SW-1:0]      s_r;
  logic [31:0]        d_r;
  logic signed [31:0] dsig_r, xold_r, xnew_r;
  logic [62:0]        num_r;
  logic [31:0]        rem_r, dmag_r;
  logic               qneg_r;
  logic [63:0]        tmul_r;
  logic [32:0]        diff_r;
  logic [55:0]        out_data_r;
  logic               out_last_r;

  logic signed [31:0] coef_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
  logic signed [31:0] b_mem    [MAX_UNKNOWNS];
  logic signed [31:0] cur_mem  [MAX_UNKNOWNS];
  logic signed [31:0] prev_mem [MAX_UNKNOWNS];

  // combinational helpers
  logic               in_acc;
  logic [5:0]         in_row, in_col;
  logic signed [31:0] in_val;
  logic               row_ok, col_ok;
  logic [CW-1:0]      coef_waddr, coef_raddr;
  logic [6:0]         n_eff;
  logic               issue;
  logic [31:0]        dmag_dom;
  logic [SW-1:0]      s_fin;
  logic [31:0]        d_fin;
  logic               fail_f, big_f, zero_f;
  logic signed [63:0] trunc_p, acc_fin, acc_cl, acc_mag;
  logic [32:0]        rem_sh;
  logic               ge;
  logic signed [31:0] sat_x;
  logic [31:0]        xmag;
  logic signed [32:0] dsub;
  logic [63:0]        lhs;
  logic               ok, allok_fin;
  logic [16:0]        iter_inc;
  logic               cur_we;
  logic [IW-1:0]      cur_waddr;
  logic signed [31:0] cur_wdata;

  always_comb begin
    in_acc = in_tvalid && in_tready;
    in_row = in_tdata[5:0];
    in_col = in_tdata[11:6];
    in_val = in_tdata[43:12];
    row_ok = {1'b0, in_row} < 7'(MAX_UNKNOWNS);
    col_ok = {1'b0, in_col} < 7'(MAX_UNKNOWNS);
    coef_waddr = CW'(in_row[IW-1:0]) * CW'(MAX_UNKNOWNS) + CW'(in_col[IW-1:0]);
    coef_raddr = CW'(ci_r) * CW'(MAX_UNKNOWNS) + CW'(cj_r);
    if (unk_r < 7'd2) n_eff = 7'd2;
    else if (unk_r > 7'(MAX_UNKNOWNS)) n_eff = 7'(MAX_UNKNOWNS);
    else n_eff = unk_r;
    issue = !iss_done_r &&
            (state_r == jls_pkg::S_DOM || state_r == jls_pkg::S_COPY ||
             state_r == jls_pkg::S_ROW);

    // dominance pass
    dmag_dom = coef_q[31] ? 32'(-coef_q) : 32'(coef_q);
    s_fin = s_r + (p1_diag_r ? '0 : SW'(dmag_dom));
    d_fin = p1_diag_r ? dmag_dom : d_r;
    fail_f = fail_r || (p1_eol_r && ({{(SW-32){1'b0}}, d_fin} < s_fin));
    big_f  = bigger_r || (p1_eol_r && ({{(SW-32){1'b0}}, d_fin} > s_fin));
    zero_f = zero_r || (p1_diag_r && coef_q == 32'sd0);

    // row accumulation: truncate product toward zero
    trunc_p = (prod_r + (prod_r[63] ? RND : 64'sd0)) >>> FRAC_BITS;
    acc_fin = acc_r - (p2_diag_r ? 64'sd0 : trunc_p);
    if (acc_fin > LIMIT) acc_cl = LIMIT;
    else if (acc_fin < -LIMIT) acc_cl = -LIMIT;
    else acc_cl = acc_fin;
    acc_mag = acc_cl[63] ? -acc_cl : acc_cl;

    // restoring divider step
    rem_sh = {rem_r, num_r[62]};
    ge = rem_sh >= {1'b0, dmag_r};

    // saturate the quotient
    if (qneg_r) begin
      if (num_r > 63'd2147483648) sat_x = 32'sh8000_0000;
      else sat_x = 32'(-num_r);
    end else begin
      if (num_r > 63'd2147483647) sat_x = 32'sh7fff_ffff;
      else sat_x = 32'(num_r);
    end

    xmag = xnew_r[31] ? 32'(-xnew_r) : 32'(xnew_r);
    dsub = 33'(xnew_r) - 33'(xold_r);
    lhs = 64'({diff_r, {FRAC_BITS{1'b0}}});
    ok = lhs <= tmul_r;
    allok_fin = allok_r && ok;
    iter_inc = {1'b0, iter_r} + 17'd1;

    cur_we    = (state_r == jls_pkg::S_CMP) ||
                (in_acc && in_tuser == jls_pkg::OP_GUESS && row_ok);
    cur_waddr = (state_r == jls_pkg::S_CMP) ? ci_r : in_row[IW-1:0];
    cur_wdata = (state_r == jls_pkg::S_CMP) ? xnew_r : in_val;
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == jls_pkg::OP_COEF && row_ok && col_ok)
      coef_mem[coef_waddr] <= in_val;
    coef_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == jls_pkg::OP_CONST && row_ok)
      b_mem[in_row[IW-1:0]] <= in_val;
    b_q <= b_mem[ci_r];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_q <= cur_mem[cj_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == jls_pkg::S_COPY && p1_v_r) prev_mem[p1_idx_r] <= cur_q;
    prev_q <= prev_mem[cj_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == jls_pkg::OP_SOLVE) begin
      s_r <= '0;
      d_r <= '0;
    end
    if (state_r == jls_pkg::S_DOM && p1_v_r) begin
      if (p1_eol_r) begin
        s_r <= '0;
        d_r <= '0;
      end else begin
        s_r <= s_fin;
        d_r <= d_fin;
      end
    end
    if (state_r == jls_pkg::S_ROW && p1_v_r) begin
      prod_r <= coef_q * prev_q;
      if (p1_diag_r) begin
        dsig_r <= coef_q;
        xold_r <= prev_q;
      end
      if (p1_first_r) acc_r <= {{32{b_q[31]}}, b_q};
    end
    if (state_r == jls_pkg::S_ROW && p2_v_r) begin
      acc_r <= acc_fin;
      if (p2_eol_r) begin
        num_r  <= acc_mag[62:0] << FRAC_BITS;
        qneg_r <= acc_cl[63] ^ dsig_r[31];
        dmag_r <= dsig_r[31] ? 32'(-dsig_r) : 32'(dsig_r);
        rem_r  <= '0;
      end
    end
    if (state_r == jls_pkg::S_DIV) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
      num_r <= {num_r[61:0], ge};
    end
    if (state_r == jls_pkg::S_SAT) xnew_r <= sat_x;
    if (state_r == jls_pkg::S_MUL) begin
      tmul_r <= tol_r * xmag;
      diff_r <= dsub[32] ? 33'(-dsub) : 33'(dsub);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jls_pkg::S_IDLE;
      ci_r        <= '0;
      cj_r        <= '0;
      nm1_r       <= '0;
      iss_done_r  <= 1'b1;
      p1_v_r      <= 1'b0;
      p1_diag_r   <= 1'b0;
      p1_eol_r    <= 1'b0;
      p1_end_r    <= 1'b0;
      p1_first_r  <= 1'b0;
      p1_idx_r    <= '0;
      p2_v_r      <= 1'b0;
      p2_diag_r   <= 1'b0;
      p2_eol_r    <= 1'b0;
      fail_r      <= 1'b0;
      bigger_r    <= 1'b0;
      zero_r      <= 1'b0;
      allok_r     <= 1'b1;
      iter_r      <= '0;
      divcnt_r    <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_last_r  <= 1'b0;
      unk_r       <= 7'd16;
      tol_r       <= 32'd655;
      maxit_r     <= 16'hffff;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          jls_pkg::CFG_UNKNOWNS: unk_r   <= cfg_data[6:0];
          jls_pkg::CFG_TOL:      tol_r   <= cfg_data;
          jls_pkg::CFG_MAXIT:    maxit_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      // read issue
      p1_v_r <= issue;
      if (issue) begin
        p1_diag_r  <= ci_r == cj_r;
        p1_eol_r   <= cj_r == nm1_r;
        p1_first_r <= cj_r == '0;
        p1_idx_r   <= cj_r;
        p1_end_r   <= (cj_r == nm1_r) &&
                      (state_r != jls_pkg::S_DOM || ci_r == nm1_r);
        if (cj_r == nm1_r) begin
          cj_r <= '0;
          if (state_r == jls_pkg::S_DOM) ci_r <= ci_r + 1'b1;
          if (state_r != jls_pkg::S_DOM || ci_r == nm1_r) iss_done_r <= 1'b1;
        end else begin
          cj_r <= cj_r + 1'b1;
        end
      end

      p2_v_r <= p1_v_r && state_r == jls_pkg::S_ROW;
      p2_diag_r <= p1_diag_r;
      p2_eol_r  <= p1_eol_r;

      unique case (state_r)
        jls_pkg::S_IDLE: begin
          if (in_acc && in_tuser == jls_pkg::OP_SOLVE) begin
            nm1_r      <= IW'(n_eff - 7'd1);
            ci_r       <= '0;
            cj_r       <= '0;
            iss_done_r <= 1'b0;
            fail_r     <= 1'b0;
            bigger_r   <= 1'b0;
            zero_r     <= 1'b0;
            iter_r     <= '0;
            state_r    <= jls_pkg::S_DOM;
          end
        end
        jls_pkg::S_DOM: begin
          if (p1_v_r) begin
            fail_r   <= fail_f;
            bigger_r <= big_f;
            zero_r   <= zero_f;
            if (p1_end_r) begin
              ci_r <= '0;
              cj_r <= '0;
              if (fail_f || !big_f || zero_f) begin
                out_data_r  <= {(fail_f || !big_f) ? jls_pkg::ST_NOT_DOM
                                                  : jls_pkg::ST_ZERO_DIAG,
                                16'd0, 32'd0, 6'd0};
                out_last_r  <= 1'b1;
                out_valid_r <= 1'b1;
                iss_done_r  <= 1'b1;
                state_r     <= jls_pkg::S_OWAIT;
              end else begin
                iss_done_r <= 1'b0;
                allok_r    <= 1'b1;
                state_r    <= jls_pkg::S_COPY;
              end
            end
          end
        end
        jls_pkg::S_COPY: begin
          if (p1_v_r && p1_end_r) begin
            cj_r       <= '0;
            iss_done_r <= 1'b0;
            state_r    <= jls_pkg::S_ROW;
          end
        end
        jls_pkg::S_ROW: begin
          if (p2_v_r && p2_eol_r) begin
            divcnt_r <= '0;
            state_r  <= jls_pkg::S_DIV;
          end
        end
        jls_pkg::S_DIV: begin
          divcnt_r <= divcnt_r + 6'd1;
          if (divcnt_r == 6'(jls_pkg::QUOT_BITS - 1)) state_r <= jls_pkg::S_SAT;
        end
        jls_pkg::S_SAT: state_r <= jls_pkg::S_MUL;
        jls_pkg::S_MUL: state_r <= jls_pkg::S_CMP;
        jls_pkg::S_CMP: begin
          cj_r <= '0;
          iss_done_r <= 1'b0;
          allok_r <= allok_fin;
          if (ci_r == nm1_r) begin
            ci_r   <= '0;
            iter_r <= iter_inc[15:0];
            if (allok_fin) begin
              out_data_r[55:54] <= jls_pkg::ST_CONVERGED;
              iss_done_r <= 1'b1;
              state_r    <= jls_pkg::S_ORD;
            end else if (iter_inc >= {1'b0, maxit_r}) begin
              out_data_r[55:54] <= jls_pkg::ST_ITER_LIM;
              iss_done_r <= 1'b1;
              state_r    <= jls_pkg::S_ORD;
            end else begin
              allok_r <= 1'b1;
              state_r <= jls_pkg::S_COPY;
            end
          end else begin
            ci_r    <= ci_r + 1'b1;
            state_r <= jls_pkg::S_ROW;
          end
        end
        jls_pkg::S_ORD: state_r <= jls_pkg::S_OLD;
        jls_pkg::S_OLD: begin
          out_data_r[53:0] <= {iter_r, cur_q, 6'(cj_r)};
          out_last_r  <= cj_r == nm1_r;
          out_valid_r <= 1'b1;
          state_r     <= jls_pkg::S_OWAIT;
        end
        jls_pkg::S_OWAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= jls_pkg::S_IDLE;
            end else begin
              cj_r    <= cj_r + 1'b1;
              state_r <= jls_pkg::S_ORD;
            end
          end
        end
        default: state_r <= jls_pkg::S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == jls_pkg::S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
